### src/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked implication, off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/smes_pkg.sv
// Types and constants of the sparse matrix entry store.
// No dependencies.
package smes_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned POS_W         = 16;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned RES_W         = 40;
  localparam int unsigned ACC_W         = VAL_W + IDX_W + 1;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SUM   = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic signed [63:0] SUM_MAX = 64'sd549755813887;
  localparam logic signed [63:0] SUM_MIN = -64'sd549755813888;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    entry_t            data;
  } ram_wr_t;

endpackage

### src/smes_entry_ram.sv
// Entry memory: row, column and value of each table slot.
// One write port, one registered read port. Uses smes_pkg.
module smes_entry_ram import smes_pkg::*; (
  input  logic             clk_i,
  input  ram_wr_t          wr_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/sparse_matrix_entry_store.sv
// Sparse matrix entry store, top level: sequencer, valid bits, scan unit.
// Uses smes_pkg, smes_entry_ram and assert_macros.svh.
//
// channel   direction  handshake               payload
// in        to block   in_valid_i / in_stall_o   command_i row_index_i column_index_i write_value_i
// out       from block out_valid_o / out_stall_i result_value_o status_o
// cfg       to block   cfg_we_i                cfg_index_i cfg_wdata_i
//
// A command taken in is worked in steps: one memory read per slot through the single
// read port, one compare/accumulate per slot, then update and result. Out-of-range
// indices and the unused command skip the scan and the update and go straight to the result.
// The next transfer in can be taken in the same cycle as the result is presented.
// in_stall_o is high while a command is in flight; a held result does not block the next
// transfer in. After reset the table is empty and both sizes are 1.
`include "assert_macros.svh"

module sparse_matrix_entry_store import smes_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic [POS_W-1:0]       row_index_i,
  input  logic [POS_W-1:0]       column_index_i,
  input  logic signed [VAL_W-1:0] write_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [RES_W-1:0] result_value_o,
  output logic [1:0]             status_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [POS_W-1:0]       cfg_wdata_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]               state_q;
  logic [POS_W-1:0]         row_count_q, column_count_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [1:0]               cmd_q;
  logic [POS_W-1:0]         row_q, col_q;
  logic [VAL_W-1:0]         val_q;
  logic [IDX_W-1:0]         idx_q, rd_idx_q, hit_idx_q, free_idx_q;
  logic                     issue_done_q, rd_pend_q, hit_q, free_q;
  logic                     slot_vld_q;
  logic [VAL_W-1:0]         hit_val_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [RES_W-1:0]  res_q, res_d, out_res_q;
  logic [1:0]               st_q, st_d, out_st_q;
  logic                     out_valid_q;

  logic                     in_xfer, out_xfer, out_free;
  logic                     skip_in;
  logic [1:0]               skip_st;
  entry_t                   rd_entry;
  ram_wr_t                  ram_wr;
  logic                     slot_vld, col_eq, pos_eq;
  logic signed [63:0]       acc_ext;

  assign in_stall_o = state_q != S_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    skip_in = 1'b0;
    skip_st = ST_OK;
    unique case (command_i)
      CMD_READ, CMD_WRITE: begin
        if (row_index_i >= row_count_q || column_index_i >= column_count_q) begin
          skip_in = 1'b1;
          skip_st = ST_RANGE;
        end
      end
      CMD_SUM: begin
        if (column_index_i >= column_count_q) begin
          skip_in = 1'b1;
          skip_st = ST_RANGE;
        end
      end
      default: skip_in = 1'b1;
    endcase
  end

  smes_entry_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_entry)
  );

  assign slot_vld = slot_vld_q;
  assign col_eq   = rd_entry.column == col_q;
  assign pos_eq   = col_eq && (rd_entry.row == row_q);
  assign acc_ext  = 64'(acc_q);

  always_comb begin
    res_d       = '0;
    st_d        = ST_OK;
    ram_wr.en   = 1'b0;
    ram_wr.addr = hit_q ? hit_idx_q : free_idx_q;
    ram_wr.data = '{row: row_q, column: col_q, value: val_q};
    unique case (cmd_q)
      CMD_READ: begin
        if (hit_q) res_d = RES_W'(signed'(hit_val_q));
      end
      CMD_WRITE: begin
        if (hit_q) begin
          res_d     = RES_W'(signed'(hit_val_q));
          ram_wr.en = state_q == S_WRITE;
        end else if (free_q) begin
          ram_wr.en = state_q == S_WRITE;
        end else begin
          st_d = ST_FULL;
        end
      end
      CMD_SUM: begin
        priority if (acc_ext > SUM_MAX) res_d = RES_W'(SUM_MAX);
        else if (acc_ext < SUM_MIN)     res_d = RES_W'(SUM_MIN);
        else                            res_d = RES_W'(acc_ext);
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= POS_W'(1);
      column_count_q <= POS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT:    row_count_q    <= cfg_wdata_i;
        REG_COLUMN_COUNT: column_count_q <= cfg_wdata_i;
        default:          row_count_q    <= row_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      issue_done_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
    end else begin
      if (out_xfer && state_q != S_FIN) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            issue_done_q <= 1'b0;
            rd_pend_q    <= 1'b0;
            hit_q        <= 1'b0;
            free_q       <= 1'b0;
            state_q      <= skip_in ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend_q <= !issue_done_q;
          if (idx_q == LAST_IDX) issue_done_q <= 1'b1;
          if (rd_pend_q) begin
            if (slot_vld && pos_eq) hit_q <= 1'b1;
            if (!slot_vld && !free_q) free_q <= 1'b1;
            if (rd_idx_q == LAST_IDX) state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (ram_wr.en && !hit_q) valid_q[free_idx_q] <= 1'b1;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_q <= command_i;
          row_q <= row_index_i;
          col_q <= column_index_i;
          val_q <= write_value_i;
          idx_q <= '0;
          acc_q <= '0;
          res_q <= '0;
          st_q  <= skip_st;
        end
      end
      S_SCAN: begin
        if (!issue_done_q) idx_q <= idx_q + IDX_W'(1);
        rd_idx_q   <= idx_q;
        slot_vld_q <= valid_q[idx_q];
        if (rd_pend_q) begin
          if (slot_vld && pos_eq) begin
            hit_idx_q <= rd_idx_q;
            hit_val_q <= rd_entry.value;
          end
          if (!slot_vld && !free_q) free_idx_q <= rd_idx_q;
          if (slot_vld && col_eq) begin
            acc_q <= acc_q + {{(ACC_W-VAL_W){rd_entry.value[VAL_W-1]}}, rd_entry.value};
          end
        end
      end
      S_WRITE: begin
        res_q <= res_d;
        st_q  <= st_d;
      end
      S_FIN: begin
        if (out_free) begin
          out_res_q <= res_q;
          out_st_q  <= st_q;
        end
      end
      default: res_q <= res_q;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_st_q;

  `ASSERT_CLK(a_accept_starts, in_xfer |=> (state_q == S_SCAN || state_q == S_FIN), "no start")
  `ASSERT_CLK(a_fin_delivers, (state_q == S_FIN && out_free) |=> out_valid_q, "no result")
  `ASSERT_CLK(a_valid_grows, $countones(valid_q) >= $past($countones(valid_q)), "entry lost")
  `ASSERT_IMPL(a_full_status, state_q == S_WRITE && st_d == ST_FULL, &valid_q, "bad full")

endmodule

### dv/sparse_matrix_entry_store_test.sv
`timescale 1ns / 1ps
// Testbench of sparse_matrix_entry_store: a directed table, then random phases over
// several matrix sizes and idle patterns, each result checked against a scoreboard model.
// Depends on smes_pkg and the RTL of the store.
module sparse_matrix_entry_store_test;
  import smes_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES + 40;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {STEP_CMD, STEP_CFG} step_kind_e;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [1:0]              status;
  } entry_result_t;

  typedef struct {
    step_kind_e              kind;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [POS_W-1:0]        cfg_data;
    logic [1:0]              cmd;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] wval;
    bit                      typed;
    logic signed [RES_W-1:0] exp_value;
    logic [1:0]              exp_status;
  } dir_step_t;

  typedef struct {
    logic [POS_W-1:0] rows;
    logic [POS_W-1:0] cols;
    int unsigned      items;
    idle_mode_e       mode;
    int unsigned      write_pct;
    int unsigned      fresh_pct;
    bit               hold;
  } phase_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              command_i;
  logic [POS_W-1:0]        row_index_i;
  logic [POS_W-1:0]        column_index_i;
  logic signed [VAL_W-1:0] write_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [RES_W-1:0] result_value_o;
  logic [1:0]              status_o;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [POS_W-1:0]        cfg_wdata_i;

  // scoreboard copy of the matrix: position {row, column} -> value
  logic [POS_W-1:0]        model_rows;
  logic [POS_W-1:0]        model_cols;
  logic signed [VAL_W-1:0] stored_value [bit [2*POS_W-1:0]];
  bit [2*POS_W-1:0]        stored_keys [$];
  entry_result_t           awaited_results [$];

  idle_mode_e  idle_mode;
  int unsigned hold_request;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned accepted_count;
  int unsigned checked_count;
  int unsigned sum_count;
  int unsigned status_count [4];

  dir_step_t directed_steps [28];
  phase_t    phases [9];

  sparse_matrix_entry_store u_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic bit count_failure();
    fail_count++;
    return fail_count <= MAX_REPORTS;
  endfunction

  function automatic bit draw_pause(bit receiver);
    case (idle_mode)
      IDLE_SEND: return !receiver && ($urandom_range(99) < 71);
      IDLE_RECV: return receiver && ($urandom_range(99) < 71);
      IDLE_BOTH: return $urandom_range(99) < 36;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic entry_result_t predict_entry_result(logic [1:0] cmd,
      logic [POS_W-1:0] row, logic [POS_W-1:0] col, logic signed [VAL_W-1:0] wval);
    entry_result_t    res;
    bit [2*POS_W-1:0] key;
    longint           acc;
    res.value  = '0;
    res.status = ST_OK;
    key        = {row, col};
    acc        = 0;
    case (cmd)
      CMD_READ, CMD_WRITE: begin
        if (row >= model_rows || col >= model_cols) begin
          res.status = ST_RANGE;
        end else if (stored_value.exists(key)) begin
          res.value = RES_W'(stored_value[key]);
          if (cmd == CMD_WRITE) stored_value[key] = wval;
        end else if (cmd == CMD_WRITE) begin
          if (stored_keys.size() < TABLE_ENTRIES) begin
            stored_value[key] = wval;
            stored_keys.push_back(key);
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      CMD_SUM: begin
        if (col >= model_cols) begin
          res.status = ST_RANGE;
        end else begin
          foreach (stored_keys[i])
            if (stored_keys[i][POS_W-1:0] == col) acc += stored_value[stored_keys[i]];
          if (acc > SUM_MAX) acc = SUM_MAX;
          if (acc < SUM_MIN) acc = SUM_MIN;
          res.value = acc[RES_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one command; returns at the edge where it was transferred.
  task automatic offer_command(logic [1:0] cmd, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
      logic signed [VAL_W-1:0] wval, bit typed, entry_result_t typed_res);
    entry_result_t res;
    while (draw_pause(1'b0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    row_index_i    <= row;
    column_index_i <= col;
    write_value_i  <= wval;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_entry_result(cmd, row, col, wval);
    if (typed) res = typed_res;
    awaited_results.push_back(res);
    accepted_count++;
    status_count[res.status]++;
    if (cmd == CMD_SUM && res.status == ST_OK) sum_count++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_ROW_COUNT) model_rows = data;
    else model_cols = data;
  endtask

  task automatic random_command(phase_t ph);
    int unsigned             pick;
    logic [1:0]              cmd;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] wval;
    pick = $urandom_range(99);
    if (pick < ph.write_pct) cmd = CMD_WRITE;
    else if (pick < ph.write_pct + (100 - ph.write_pct) / 2) cmd = CMD_READ;
    else if (pick < 92) cmd = CMD_SUM;
    else cmd = CMD_NOP;
    row  = POS_W'($urandom_range(16'hffff));
    col  = POS_W'($urandom_range(16'hffff));
    pick = $urandom_range(99);
    if (pick >= 10) begin
      if (pick < 10 + ph.fresh_pct || stored_keys.size() == 0) begin
        if (model_rows != 0) row = POS_W'($urandom_range(model_rows - 1));
        if (model_cols != 0) col = POS_W'($urandom_range(model_cols - 1));
      end else begin
        {row, col} = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end
    end
    case ($urandom_range(7))
      0:       wval = 32'sh7fffffff;
      1:       wval = 32'sh80000000;
      2:       wval = '0;
      3:       wval = '1;
      default: wval = $urandom;
    endcase
    offer_command(cmd, row, col, wval, 1'b0, '0);
  endtask

  // receiver: random stalls per idle mode, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= draw_pause(1'b1);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    entry_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_count++;
      if (awaited_results.size() == 0) begin
        if (count_failure())
          $display("%0t: unexpected transfer out, value %0d status %0d",
                   $time, result_value_o, status_o);
      end else begin
        want = awaited_results.pop_front();
        if (result_value_o !== want.value && count_failure())
          $display("%0t: result_value mismatch, expected %0d, got %0d",
                   $time, want.value, result_value_o);
        if (status_o !== want.status && count_failure())
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, status_o);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, awaited_results.size());
    $display("FAIL sparse_matrix_entry_store");
    $finish;
  end

  initial begin : stimulus
    entry_result_t typed_res;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_NOP;
    row_index_i    = '0;
    column_index_i = '0;
    write_value_i  = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_ROW_COUNT;
    cfg_wdata_i    = '0;
    model_rows     = 16'd1;
    model_cols     = 16'd1;
    idle_mode      = IDLE_NONE;
    hold_request   = 0;
    fail_count     = 0;
    accepted_count = 0;
    checked_count  = 0;
    sum_count      = 0;
    foreach (status_count[i]) status_count[i] = 0;

    directed_steps = '{
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'd0, 16'd0, 32'sd0, 1, 40'sd0, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'd0, 16'd0, 32'sh7fffffff, 1, 40'sd0,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'd0, 16'd0, 32'sd0, 1, 40'sd2147483647,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'd0, 16'd0, 32'sh80000000, 1,
        40'sd2147483647, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'hffff, 16'd0, 32'shffffffff, 1,
        -40'sd2147483648, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'd1, 16'd0, 32'sd0, 1, 40'sd0, ST_RANGE},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'd0, 16'd1, 32'sh5a5a5a5a, 1, 40'sd0,
        ST_RANGE},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'd0, 16'd1, 32'sd0, 1, 40'sd0, ST_RANGE},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_NOP, 16'hffff, 16'hffff, 32'shffffffff, 1, 40'sd0,
        ST_OK},
      '{STEP_CFG, REG_ROW_COUNT, 16'hffff, CMD_NOP, 16'd0, 16'd0, 32'sd0, 0, 40'sd0, ST_OK},
      '{STEP_CFG, REG_COLUMN_COUNT, 16'hffff, CMD_NOP, 16'd0, 16'd0, 32'sd0, 0, 40'sd0, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'hfffe, 16'hfffe, 32'sd0, 1, 40'sd0,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'hfffe, 16'hfffe, 32'sd0, 1, 40'sd0, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'hfffe, 16'hfffe, 32'sd5, 1, 40'sd0,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'hffff, 16'd0, 32'sd0, 1, 40'sd0, ST_RANGE},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'hfffe, 16'd0, 32'sh7fffffff, 1, 40'sd0,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'd0, 16'd0, 32'sd0, 1, -40'sd1, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'd0, 16'hfffe, 32'sd0, 1, 40'sd5, ST_OK},
      '{STEP_CFG, REG_ROW_COUNT, 16'd0, CMD_NOP, 16'd0, 16'd0, 32'sd0, 0, 40'sd0, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'd0, 16'd0, 32'sd0, 1, 40'sd0, ST_RANGE},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'd0, 16'd0, 32'sd0, 1, -40'sd1, ST_OK},
      '{STEP_CFG, REG_ROW_COUNT, 16'd3, CMD_NOP, 16'd0, 16'd0, 32'sd0, 0, 40'sd0, ST_OK},
      '{STEP_CFG, REG_COLUMN_COUNT, 16'd0, CMD_NOP, 16'd0, 16'd0, 32'sd0, 0, 40'sd0, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'd0, 16'd0, 32'sd0, 1, 40'sd0, ST_RANGE},
      '{STEP_CFG, REG_COLUMN_COUNT, 16'd2, CMD_NOP, 16'd0, 16'd0, 32'sd0, 0, 40'sd0, ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_READ, 16'd0, 16'd0, 32'sd0, 1, -40'sd2147483648,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_WRITE, 16'd2, 16'd1, 32'sh12345678, 0, 40'sd0,
        ST_OK},
      '{STEP_CMD, REG_ROW_COUNT, 16'd0, CMD_SUM, 16'd0, 16'd1, 32'sd0, 0, 40'sd0, ST_OK}
    };

    // rows, cols, items, idling, write %, in-range fresh position %, long hold-off
    phases = '{
      '{16'd4,     16'd4,     200, IDLE_NONE, 40, 45, 1'b0},
      '{16'hffff,  16'hffff,  200, IDLE_SEND, 40, 45, 1'b0},
      '{16'd16,    16'd3,     220, IDLE_RECV, 40, 45, 1'b0},
      '{16'd1,     16'hffff,  180, IDLE_BOTH, 40, 45, 1'b0},
      '{16'hffff,  16'd1,     160, IDLE_NONE, 40, 45, 1'b0},
      '{16'd0,     16'd9,      40, IDLE_BOTH, 40, 45, 1'b0},
      '{16'd11,    16'd0,      40, IDLE_SEND, 40, 45, 1'b0},
      '{16'd600,   16'd8,     380, IDLE_RECV, 70, 70, 1'b1},
      '{16'd5,     16'd5,     120, IDLE_BOTH, 40, 30, 1'b0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[s]) begin
      if (directed_steps[s].kind == STEP_CFG) begin
        drain_results();
        write_size(directed_steps[s].cfg_index, directed_steps[s].cfg_data);
        cfg_we_i <= 1'b0;
      end else begin
        typed_res.value  = directed_steps[s].exp_value;
        typed_res.status = directed_steps[s].exp_status;
        offer_command(directed_steps[s].cmd, directed_steps[s].row, directed_steps[s].col,
                      directed_steps[s].wval, directed_steps[s].typed, typed_res);
      end
    end

    foreach (phases[p]) begin
      drain_results();
      idle_mode = phases[p].mode;
      write_size(REG_ROW_COUNT, phases[p].rows);
      write_size(REG_COLUMN_COUNT, phases[p].cols);
      cfg_we_i <= 1'b0;
      for (int n = 0; n < phases[p].items; n++) begin
        if (phases[p].hold && n == phases[p].items / 4) hold_request = HOLD_CYCLES;
        random_command(phases[p]);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands: %0d ok, %0d out of range, %0d table full, %0d column sums",
             accepted_count, status_count[ST_OK], status_count[ST_RANGE],
             status_count[ST_FULL], sum_count);
    $display("Checked %0d transfers out over %0d size settings, %0d mismatches",
             checked_count, $size(phases) + 5, fail_count);
    if (fail_count == 0) begin
      $display("PASS sparse_matrix_entry_store");
    end else begin
      $display("FAIL sparse_matrix_entry_store");
    end
    $finish;
  end

endmodule
